FILE: rtl/sds_pkg.sv
// Shared constants, codes and control structs for the shared double stack.
package sds_pkg;

  localparam int DEPTH   = 64;
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [1:0] SEL_LOWER = 2'd1;
  localparam logic [1:0] SEL_UPPER = 2'd2;

  typedef struct packed {
    logic       push_lo;
    logic       push_hi;
    logic       pop_lo;
    logic       pop_hi;
    logic       load_now;
    logic       load_pop;
    logic [1:0] status;
  } sds_cmd_t;

  typedef struct packed {
    logic full;
    logic lo_empty;
    logic hi_empty;
  } sds_stat_t;

endpackage

FILE: rtl/sds_ctrl.sv
// Controller: handshake, operation decode and the pop read sequence.
module sds_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             kind_i,
  input  logic [1:0]       stack_select_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  sds_pkg::sds_stat_t stat_i,
  output sds_pkg::sds_cmd_t  cmd_o
);
  import sds_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic       state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       pop_ok;
  logic [1:0] status;
  logic       push_lo, push_hi, pop_lo, pop_hi;

  assign in_stall_o  = (state_q != S_IDLE) || (out_valid_q && out_stall_i);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    status  = ST_OK;
    push_lo = 1'b0;
    push_hi = 1'b0;
    pop_lo  = 1'b0;
    pop_hi  = 1'b0;
    if (kind_i == KIND_PUSH) begin
      if (stat_i.full) begin
        status = ST_FULL;
      end else if (stack_select_i == SEL_LOWER) begin
        push_lo = 1'b1;
      end else if (stack_select_i == SEL_UPPER) begin
        push_hi = 1'b1;
      end else begin
        status = ST_BAD;
      end
    end else begin
      if (stack_select_i == SEL_LOWER) begin
        if (stat_i.lo_empty) status = ST_EMPTY;
        else pop_lo = 1'b1;
      end else if (stack_select_i == SEL_UPPER) begin
        if (stat_i.hi_empty) status = ST_EMPTY;
        else pop_hi = 1'b1;
      end else begin
        status = ST_BAD;
      end
    end
  end

  assign pop_ok = pop_lo || pop_hi;

  always_comb begin
    cmd_o.push_lo  = accept && push_lo;
    cmd_o.push_hi  = accept && push_hi;
    cmd_o.pop_lo   = accept && pop_lo;
    cmd_o.pop_hi   = accept && pop_hi;
    cmd_o.load_now = accept && !pop_ok;
    cmd_o.load_pop = (state_q == S_READ);
    cmd_o.status   = (state_q == S_READ) ? ST_OK : status;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (pop_ok) state_d = S_READ;
          else out_valid_d = 1'b1;
        end
      end
      S_READ: begin
        state_d     = S_IDLE;
        out_valid_d = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/sds_dpath.sv
// Datapath: stack counts, shared element store and result register.
module sds_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [sds_pkg::DATA_W-1:0] push_value_i,
  input  sds_pkg::sds_cmd_t          cmd_i,
  output sds_pkg::sds_stat_t         stat_o,
  output logic [1:0]                 status_o,
  output logic [sds_pkg::DATA_W-1:0] pop_value_o
);
  import sds_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_q;
  logic [CNT_W-1:0]  lo_cnt_q, lo_cnt_d;
  logic [CNT_W-1:0]  hi_cnt_q, hi_cnt_d;
  logic [CNT_W:0]    total;
  logic [CNT_W-1:0]  lo_pop_idx, hi_push_idx, hi_pop_idx;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [1:0]        status_q;
  logic [DATA_W-1:0] pop_value_q;

  assign total           = {1'b0, lo_cnt_q} + {1'b0, hi_cnt_q};
  assign stat_o.full     = total >= (CNT_W + 1)'(DEPTH);
  assign stat_o.lo_empty = (lo_cnt_q == '0);
  assign stat_o.hi_empty = (hi_cnt_q == '0);

  assign lo_pop_idx  = lo_cnt_q - CNT_W'(1);
  assign hi_push_idx = CNT_W'(DEPTH - 1) - hi_cnt_q;
  assign hi_pop_idx  = CNT_W'(DEPTH) - hi_cnt_q;

  assign wr_addr = cmd_i.push_hi ? hi_push_idx[ADDR_W-1:0] : lo_cnt_q[ADDR_W-1:0];
  assign rd_addr = cmd_i.pop_hi ? hi_pop_idx[ADDR_W-1:0] : lo_pop_idx[ADDR_W-1:0];

  always_comb begin
    lo_cnt_d = lo_cnt_q;
    hi_cnt_d = hi_cnt_q;
    if (cmd_i.push_lo) lo_cnt_d = lo_cnt_q + CNT_W'(1);
    if (cmd_i.pop_lo)  lo_cnt_d = lo_cnt_q - CNT_W'(1);
    if (cmd_i.push_hi) hi_cnt_d = hi_cnt_q + CNT_W'(1);
    if (cmd_i.pop_hi)  hi_cnt_d = hi_cnt_q - CNT_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_cnt_q <= '0;
      hi_cnt_q <= '0;
    end else begin
      lo_cnt_q <= lo_cnt_d;
      hi_cnt_q <= hi_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push_lo || cmd_i.push_hi) mem[wr_addr] <= push_value_i;
    if (cmd_i.pop_lo || cmd_i.pop_hi) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_now) begin
      status_q    <= cmd_i.status;
      pop_value_q <= '0;
    end else if (cmd_i.load_pop) begin
      status_q    <= cmd_i.status;
      pop_value_q <= rd_q;
    end
  end

  assign status_o    = status_q;
  assign pop_value_o = pop_value_q;

endmodule

FILE: rtl/shared_double_stack_core.sv
// Top level of the shared double stack: two stacks growing toward each other.
//
// Input channel: in_valid_i / in_stall_o with kind_i (0 push, 1 pop),
// stack_select_i (1 lower stack, 2 upper stack) and push_value_i.
// Output channel: out_valid_o / out_stall_i with status_o (0 ok, 1 full,
// 2 empty, 3 bad stack number) and pop_value_o (zero unless a pop succeeds).
// Every input transfer yields exactly one output transfer, in order.
// A push or a failed operation shows its result the cycle after its
// transfer; a successful pop passes the registered element store read, then
// the result register. Throughput: one item per cycle for pushes and failed
// operations while the output is not stalled; a successful pop holds off
// the next item during its read. The block holds one pending result in its
// output register and accepts the next item in the cycle that result is
// taken or once it is gone. Reset empties both stacks and drops any pending
// result; store contents are not cleared. While out_stall_i holds a result,
// in_stall_o stays high and the result does not change.
module shared_double_stack_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       kind_i,
  input  logic [1:0]                 stack_select_i,
  input  logic [sds_pkg::DATA_W-1:0] push_value_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 status_o,
  output logic [sds_pkg::DATA_W-1:0] pop_value_o
);
  import sds_pkg::*;

  sds_cmd_t  cmd;
  sds_stat_t stat;

  sds_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .stack_select_i (stack_select_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  sds_dpath u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_value_i (push_value_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .status_o     (status_o),
    .pop_value_o  (pop_value_o)
  );

endmodule

FILE: rtl/sds_checker.sv
// Port-level checker for the shared double stack, bound to the top level.
module sds_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       kind_i,
  input logic [1:0]                 stack_select_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [1:0]                 status_o,
  input logic [sds_pkg::DATA_W-1:0] pop_value_o
);
  import sds_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o) && $stable(pop_value_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> pop_value_o == '0)
    else $error("failed operation returned nonzero value");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && kind_i == KIND_PUSH |=> out_valid_o && pop_value_o == '0 && status_o != ST_EMPTY)
    else $error("push result wrong");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && kind_i == KIND_POP && stack_select_i != SEL_LOWER
      && stack_select_i != SEL_UPPER |=> out_valid_o && status_o == ST_BAD)
    else $error("bad stack number not reported");

endmodule

bind shared_double_stack_core sds_checker u_sds_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .kind_i         (kind_i),
  .stack_select_i (stack_select_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .status_o       (status_o),
  .pop_value_o    (pop_value_o)
);

FILE: test/tb_top.sv
// Self-checking testbench for shared_double_stack_core: stack scoreboard plus driver tasks.
`timescale 1ns / 1ps

import sds_pkg::*;

typedef struct packed {
  logic [1:0]        status;
  logic [DATA_W-1:0] value;
} stack_result_t;

class stack_scoreboard;
  logic [DATA_W-1:0] words [DEPTH];
  int unsigned       lower_cnt;
  int unsigned       upper_cnt;
  stack_result_t     expected_q[$];
  int                errors;
  int                accepted;
  int                pushes;
  int                pops;
  int                status_seen[4];

  function void flag(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void note_request(logic kind, logic [1:0] sel, logic [DATA_W-1:0] value);
    stack_result_t r;
    r.status = ST_OK;
    r.value  = '0;
    accepted++;
    if (kind == KIND_PUSH) begin
      pushes++;
      if (lower_cnt + upper_cnt >= DEPTH) begin
        r.status = ST_FULL;
      end else if (sel == SEL_LOWER) begin
        words[lower_cnt] = value;
        lower_cnt++;
      end else if (sel == SEL_UPPER) begin
        words[DEPTH - 1 - upper_cnt] = value;
        upper_cnt++;
      end else begin
        r.status = ST_BAD;
      end
    end else begin
      pops++;
      if (sel == SEL_LOWER) begin
        if (lower_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          lower_cnt--;
          r.value = words[lower_cnt];
        end
      end else if (sel == SEL_UPPER) begin
        if (upper_cnt == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value = words[DEPTH - upper_cnt];
          upper_cnt--;
        end
      end else begin
        r.status = ST_BAD;
      end
    end
    status_seen[r.status]++;
    expected_q.push_back(r);
  endfunction

  function void check_result(logic [1:0] status, logic [DATA_W-1:0] value);
    stack_result_t exp_r;
    if (expected_q.size() == 0) begin
      flag($sformatf("unexpected result: status %0d value %h", status, value));
      return;
    end
    exp_r = expected_q.pop_front();
    if (status !== exp_r.status)
      flag($sformatf("status mismatch: expected %0d, got %0d", exp_r.status, status));
    if (value !== exp_r.value)
      flag($sformatf("pop value mismatch: expected %h, got %h", exp_r.value, value));
  endfunction
endclass

module tb_top;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_e;

  localparam int RANDOM_OPS = 1400;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 300000;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              kind_i = KIND_PUSH;
  logic [1:0]        stack_select_i = '0;
  logic [DATA_W-1:0] push_value_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [1:0]        status_o;
  logic [DATA_W-1:0] pop_value_o;

  stack_scoreboard sb = new();
  int unsigned     cycle_count = 0;
  int              burst_left = 0;

  shared_double_stack_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .stack_select_i (stack_select_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .pop_value_o    (pop_value_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL shared_double_stack_core");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(status_o, pop_value_o);
  end

  // Hold a transfer until the block takes it.
  task automatic send_op(input logic kind, input logic [1:0] sel,
                         input logic [DATA_W-1:0] value);
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    stack_select_i <= sel;
    push_value_i   <= value;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_request(kind, sel, value);
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
  endtask

  task automatic op(input logic kind, input logic [1:0] sel, input logic [DATA_W-1:0] value);
    pace();
    send_op(kind, sel, value);
  endtask

  initial begin
    int span;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (sb.accepted >= 400 && sb.accepted < 400 + HOLD_CYCLES) begin
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      span = $urandom_range(10, 80);
      case ($urandom_range(0, 3))
        0: begin
          for (int k = 0; k < span; k++) begin
            out_stall_i <= 1'b0;
            @(posedge clk_i);
          end
        end
        1: begin
          for (int k = 0; k < span; k++) begin
            out_stall_i <= 1'($urandom_range(0, 1));
            @(posedge clk_i);
          end
        end
        2: begin
          for (int k = 0; k < span; k++) begin
            out_stall_i <= (k % 3 == 0);
            @(posedge clk_i);
          end
        end
        default: begin
          for (int k = 0; k < span; k++) begin
            out_stall_i <= ($urandom_range(0, 7) == 0);
            @(posedge clk_i);
          end
        end
      endcase
    end
  end

  initial begin
    phase_e            ph;
    int                span;
    int                roll;
    logic              k;
    logic [1:0]        s;
    logic [DATA_W-1:0] v;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    op(KIND_POP,  SEL_LOWER, 32'h1234_5678);
    op(KIND_POP,  SEL_UPPER, '0);
    op(KIND_POP,  2'd0,      '0);
    op(KIND_POP,  2'd3,      '1);
    op(KIND_PUSH, 2'd0,      32'hDEAD_BEEF);
    op(KIND_PUSH, 2'd3,      '1);
    op(KIND_PUSH, SEL_LOWER, '0);
    op(KIND_PUSH, SEL_LOWER, '1);
    op(KIND_PUSH, SEL_UPPER, 32'h8000_0000);
    op(KIND_PUSH, SEL_UPPER, 32'h0000_0001);
    op(KIND_POP,  2'd3,      '0);
    op(KIND_POP,  2'd0,      '0);
    op(KIND_POP,  SEL_UPPER, '0);
    op(KIND_POP,  SEL_LOWER, '0);
    op(KIND_POP,  SEL_LOWER, '0);
    op(KIND_POP,  SEL_LOWER, '0);
    op(KIND_POP,  SEL_UPPER, '0);
    op(KIND_POP,  SEL_UPPER, '0);
    op(KIND_PUSH, SEL_LOWER, 32'h5555_5555);
    op(KIND_PUSH, SEL_UPPER, 32'hAAAA_AAAA);
    op(KIND_POP,  SEL_LOWER, '0);
    op(KIND_POP,  SEL_UPPER, '0);

    while (sb.accepted < RANDOM_OPS + 22) begin
      ph   = phase_e'($urandom_range(0, 3));
      span = $urandom_range(40, 150);
      repeat (span) begin
        roll = $urandom_range(0, 99);
        case (ph)
          PH_FILL:  k = (roll < 85) ? KIND_PUSH : KIND_POP;
          PH_DRAIN: k = (roll < 85) ? KIND_POP : KIND_PUSH;
          default:  k = roll[0];
        endcase
        if (ph == PH_NOISE) s = 2'($urandom_range(0, 3));
        else if ($urandom_range(0, 9) == 0) s = $urandom_range(0, 1) ? 2'd3 : 2'd0;
        else s = $urandom_range(0, 1) ? SEL_UPPER : SEL_LOWER;
        case ($urandom_range(0, 9))
          0:       v = '0;
          1:       v = '1;
          default: v = $urandom;
        endcase
        op(k, s, v);
      end
    end
    in_valid_i <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Covered %0d transfers (%0d push, %0d pop) with a %0d-cycle output hold-off.",
             sb.accepted, sb.pushes, sb.pops, HOLD_CYCLES);
    $display("Outcomes: %0d ok, %0d full, %0d empty, %0d bad stack; %0d mismatches.",
             sb.status_seen[ST_OK], sb.status_seen[ST_FULL], sb.status_seen[ST_EMPTY],
             sb.status_seen[ST_BAD], sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS shared_double_stack_core");
    end else begin
      $display("FAIL shared_double_stack_core");
    end
    $finish;
  end

endmodule
